// ===== hdl/reb_pkg.sv =====
// Shared types, constants and the quadrature transition decode for the
// rotary encoder with push button. No dependencies.
`default_nettype none

package reb_pkg;

	localparam int TIME_WIDTH = 32;

	typedef logic [TIME_WIDTH-1:0] time_t;
	typedef logic signed [8:0]     step_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_BLOCK_ENABLE       = 3'd0,
		REG_BUTTON_PRESENT     = 3'd1,
		REG_DEBOUNCE_MS        = 3'd2,
		REG_LONG_PRESS_MS      = 3'd3,
		REG_LONG_PRESS_ENABLE  = 3'd4,
		REG_ACCEL_ENABLE       = 3'd5,
		REG_ACCEL_RATE         = 3'd6,
		REG_ACCEL_THRESHOLD_MS = 3'd7
	} reg_index_t;

	localparam logic        RST_BLOCK_ENABLE       = 1'b1;
	localparam logic        RST_BUTTON_PRESENT     = 1'b1;
	localparam logic [15:0] RST_DEBOUNCE_MS        = 16'd5;
	localparam logic [15:0] RST_LONG_PRESS_MS      = 16'd1000;
	localparam logic        RST_LONG_PRESS_ENABLE  = 1'b0;
	localparam logic        RST_ACCEL_ENABLE       = 1'b0;
	localparam logic [7:0]  RST_ACCEL_RATE         = 8'd5;
	localparam logic [15:0] RST_ACCEL_THRESHOLD_MS = 16'd100;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// old phase in the upper two bits, new phase in the lower two
	function automatic dir_t step_dir(input logic [1:0] old_phase, input logic [1:0] new_phase);
		logic [3:0] idx;
		dir_t       d;
		idx = {old_phase, new_phase};
		case (idx) inside
			4'b0001, 4'b0111, 4'b1110, 4'b1000: d = DIR_CW;
			4'b0010, 4'b1011, 4'b1101, 4'b0100: d = DIR_CCW;
			default:                            d = DIR_NONE;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/rotary_encoder_with_button.sv =====
// Rotary encoder with push button: quadrature decode, acceleration,
// button debounce, press and long-press events. Uses reb_pkg.
// An accepted poll beat passes the input register, then the result register,
// to become its result beat. One poll per cycle while the result side does not stall.
// Reset (arst_n low, asynchronous): configuration returns to its defaults,
// decoder and button state resets (button taken as released), both pipeline stages empty.
`default_nettype none

module rotary_encoder_with_button
	import reb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        pin_a,
	input  wire logic        pin_b,
	input  wire logic        button_level,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             rotation_event,
	output logic signed [8:0] step_value,
	output logic             press_event,
	output logic             long_press_event,
	output logic             button_debounced,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	// configuration
	logic        block_enable_q, button_present_q, long_press_enable_q, accel_enable_q;
	logic [15:0] debounce_ms_q, long_press_ms_q, accel_threshold_ms_q;
	logic [7:0]  accel_rate_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  phase_s1;
	logic        btn_s1;
	time_t       now_s1;

	// decoder and button state
	logic        primed_q, button_stable_q, button_prev_q, long_done_q;
	logic [1:0]  last_phase_q;
	step_t       increment_q;
	time_t       enc_time_q, rot_time_q, btn_change_q, press_start_q;

	// result register
	logic        out_valid_q, res_rot_q, res_press_q, res_long_q, res_btn_q;
	step_t       res_step_q;

	logic        out_blocked, fire;

	// next state
	logic        n_primed, n_stable, n_prev, n_done;
	logic [1:0]  n_last_phase;
	step_t       n_inc;
	time_t       n_enc_time, n_rot_time, n_change, n_press_start;
	logic        rot, press, lng;
	dir_t        dir;
	step_t       fast_step;

	assign out_blocked = out_valid_q & out_stall;
	assign fire        = valid_s1 & ~out_blocked;
	assign in_stall    = valid_s1 & out_blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_enable_q       <= RST_BLOCK_ENABLE;
			button_present_q     <= RST_BUTTON_PRESENT;
			debounce_ms_q        <= RST_DEBOUNCE_MS;
			long_press_ms_q      <= RST_LONG_PRESS_MS;
			long_press_enable_q  <= RST_LONG_PRESS_ENABLE;
			accel_enable_q       <= RST_ACCEL_ENABLE;
			accel_rate_q         <= RST_ACCEL_RATE;
			accel_threshold_ms_q <= RST_ACCEL_THRESHOLD_MS;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_BLOCK_ENABLE:       block_enable_q       <= cfg_data[0];
				REG_BUTTON_PRESENT:     button_present_q     <= cfg_data[0];
				REG_DEBOUNCE_MS:        debounce_ms_q        <= cfg_data;
				REG_LONG_PRESS_MS:      long_press_ms_q      <= cfg_data;
				REG_LONG_PRESS_ENABLE:  long_press_enable_q  <= cfg_data[0];
				REG_ACCEL_ENABLE:       accel_enable_q       <= cfg_data[0];
				REG_ACCEL_RATE:         accel_rate_q         <= cfg_data[7:0];
				REG_ACCEL_THRESHOLD_MS: accel_threshold_ms_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			phase_s1 <= {pin_a, pin_b};
			btn_s1   <= button_level;
			now_s1   <= TIME_WIDTH'(now_ms);
		end
	end

	// rate times the step direction; a zero rate gives a zero step
	assign fast_step = (dir == DIR_CCW) ? -step_t'({1'b0, accel_rate_q})
	                                    : step_t'({1'b0, accel_rate_q});

	always_comb begin
		n_primed      = primed_q;
		n_last_phase  = last_phase_q;
		n_inc         = increment_q;
		n_enc_time    = enc_time_q;
		n_rot_time    = rot_time_q;
		n_stable      = button_stable_q;
		n_prev        = button_prev_q;
		n_change      = btn_change_q;
		n_press_start = press_start_q;
		n_done        = long_done_q;
		rot           = 1'b0;
		press         = 1'b0;
		lng           = 1'b0;
		dir           = step_dir(last_phase_q, phase_s1);

		if (!block_enable_q) begin
			n_inc = '0;
		end else if (!primed_q) begin
			n_last_phase = phase_s1;
			n_primed     = 1'b1;
		end else begin
			if (phase_s1 != last_phase_q) begin
				if ((now_s1 - enc_time_q) >= TIME_WIDTH'(debounce_ms_q)) begin
					case (dir)
						DIR_CW:  n_inc = 9'sd1;
						DIR_CCW: n_inc = -9'sd1;
						default: n_inc = '0;
					endcase
					if (dir != DIR_NONE && accel_enable_q) begin
						if ((now_s1 - rot_time_q) < TIME_WIDTH'(accel_threshold_ms_q))
							n_inc = fast_step;
						n_rot_time = now_s1;
					end
					rot        = (n_inc != '0);
					n_enc_time = now_s1;
				end
				n_last_phase = phase_s1;
			end
			if (button_present_q) begin
				if (btn_s1 != button_prev_q)
					n_change = now_s1;
				if ((now_s1 - n_change) >= TIME_WIDTH'(debounce_ms_q) &&
				    btn_s1 != button_stable_q) begin
					n_stable = btn_s1;
					n_done   = 1'b0;
					if (!btn_s1) begin
						n_press_start = now_s1;
						press         = 1'b1;
					end
				end
				if (!n_stable && !n_done && long_press_enable_q &&
				    (now_s1 - n_press_start) >= TIME_WIDTH'(long_press_ms_q)) begin
					n_done = 1'b1;
					lng    = 1'b1;
				end
				n_prev = btn_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q        <= 1'b0;
			last_phase_q    <= '0;
			increment_q     <= '0;
			enc_time_q      <= '0;
			rot_time_q      <= '0;
			button_stable_q <= 1'b1;
			button_prev_q   <= 1'b1;
			btn_change_q    <= '0;
			press_start_q   <= '0;
			long_done_q     <= 1'b0;
		end else if (fire) begin
			primed_q        <= n_primed;
			last_phase_q    <= n_last_phase;
			increment_q     <= n_inc;
			enc_time_q      <= n_enc_time;
			rot_time_q      <= n_rot_time;
			button_stable_q <= n_stable;
			button_prev_q   <= n_prev;
			btn_change_q    <= n_change;
			press_start_q   <= n_press_start;
			long_done_q     <= n_done;
		end else if (cfg_we && reg_index_t'(cfg_index) == REG_BLOCK_ENABLE && !cfg_data[0]) begin
			// disabling drops the stored step, unless a poll is taken in the same cycle
			increment_q <= '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_rot_q   <= rot;
			res_step_q  <= n_inc;
			res_press_q <= press;
			res_long_q  <= lng;
			res_btn_q   <= n_stable;
		end
	end

	assign out_valid        = out_valid_q;
	assign rotation_event   = res_rot_q;
	assign step_value       = res_step_q;
	assign press_event      = res_press_q;
	assign long_press_event = res_long_q;
	assign button_debounced = res_btn_q;

	a_rot_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rotation_event |-> step_value != '0)
		else $error("rotation beat with zero step");

	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (press_event || long_press_event) |-> !button_debounced)
		else $error("press event while debounced level released");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with result side free");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step_value) && $stable(button_debounced))
		else $error("stalled result beat changed");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for rotary_encoder_with_button: directed poll table, then random phases
// with own register settings, checked against table values or an in-bench decoder.
// Depends on reb_pkg for the register indexes and the time and step types.

module tb;
	import reb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200_000;
	// transitions indexed by {old phase, new phase}
	localparam logic [15:0] CW_MOVES  = 16'h4182;
	localparam logic [15:0] CCW_MOVES = 16'h2814;

	typedef struct packed {
		logic  rot;
		step_t step;
		logic  press;
		logic  lng;
		logic  btn;
	} poll_result_t;

	typedef enum bit {ROW_POLL, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t    kind;
		logic         a;
		logic         b;
		logic         btn;
		time_t        now;
		reg_index_t   idx;
		logic [15:0]  data;
		bit           fixed;
		poll_result_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_stall;
	logic pin_a, pin_b, button_level;
	logic [31:0] now_ms;
	logic out_valid, out_stall;
	logic rotation_event, press_event, long_press_event, button_debounced;
	logic signed [8:0] step_value;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// decoder copy: configuration
	logic cfg_en, cfg_btn, cfg_long_en, cfg_accel_en;
	logic [15:0] cfg_debounce, cfg_long_ms, cfg_thresh;
	logic [7:0] cfg_rate;
	// decoder copy: state
	logic armed, long_fired, btn_settled, btn_last_raw;
	logic [1:0] held_phase;
	step_t step_now;
	time_t enc_stamp, spin_stamp, raw_stamp, press_stamp;

	poll_result_t pending_reports[$];
	poll_result_t got_report, want_report;
	stim_row_t directed_rows[$];

	// random walk of the encoder and button
	logic [1:0] ph_now, ph_pos;
	time_t clk_ms;
	bit spin_cw, btn_goal, btn_raw, idle_on;
	int bounce_left, hold_left;

	int faults, reports_seen, polls_sent, settings_used, cycles;

	rotary_encoder_with_button dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.pin_a            (pin_a),
		.pin_b            (pin_b),
		.button_level     (button_level),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.rotation_event   (rotation_event),
		.step_value       (step_value),
		.press_event      (press_event),
		.long_press_event (long_press_event),
		.button_debounced (button_debounced),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void apply_reg(reg_index_t idx, logic [15:0] data);
		case (idx)
			REG_BLOCK_ENABLE: begin
				cfg_en = data[0];
				if (!data[0])
					step_now = '0;
			end
			REG_BUTTON_PRESENT:     cfg_btn      = data[0];
			REG_DEBOUNCE_MS:        cfg_debounce = data;
			REG_LONG_PRESS_MS:      cfg_long_ms  = data;
			REG_LONG_PRESS_ENABLE:  cfg_long_en  = data[0];
			REG_ACCEL_ENABLE:       cfg_accel_en = data[0];
			REG_ACCEL_RATE:         cfg_rate     = data[7:0];
			REG_ACCEL_THRESHOLD_MS: cfg_thresh   = data;
			default: ;
		endcase
	endfunction

	function automatic poll_result_t decode_poll(logic a, logic b, logic btn, time_t now);
		poll_result_t r;
		logic [1:0] ph;
		logic [3:0] move;
		int delta;
		r = '0;
		ph = {a, b};
		move = {held_phase, ph};
		if (!cfg_en) begin
			step_now = '0;
		end else if (!armed) begin
			// first live poll only latches the phase
			held_phase = ph;
			armed = 1'b1;
		end else begin
			if (ph != held_phase) begin
				if (time_t'(now - enc_stamp) >= cfg_debounce) begin
					delta = CW_MOVES[move] ? 1 : (CCW_MOVES[move] ? -1 : 0);
					if (delta != 0 && cfg_accel_en) begin
						if (time_t'(now - spin_stamp) < cfg_thresh)
							delta = delta * int'(cfg_rate);
						spin_stamp = now;
					end
					step_now = step_t'(delta);
					r.rot = (delta != 0);
					enc_stamp = now;
				end
				held_phase = ph;
			end
			if (cfg_btn) begin
				if (btn != btn_last_raw)
					raw_stamp = now;
				if (time_t'(now - raw_stamp) >= cfg_debounce && btn != btn_settled) begin
					btn_settled = btn;
					long_fired = 1'b0;
					if (!btn) begin
						press_stamp = now;
						r.press = 1'b1;
					end
				end
				if (!btn_settled && !long_fired && cfg_long_en &&
				    time_t'(now - press_stamp) >= cfg_long_ms) begin
					long_fired = 1'b1;
					r.lng = 1'b1;
				end
				btn_last_raw = btn;
			end
		end
		r.step = step_now;
		r.btn = btn_settled;
		return r;
	endfunction

	function automatic stim_row_t poll_row(logic a, logic b, logic btn, time_t now,
	                                       bit fixed = 1'b0, poll_result_t want = '0);
		stim_row_t r;
		r = '0;
		r.kind = ROW_POLL;
		r.a = a;
		r.b = b;
		r.btn = btn;
		r.now = now;
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	function automatic stim_row_t write_row(reg_index_t idx, logic [15:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	task automatic log_fault(string msg);
		faults++;
		if (faults <= 10)
			$display("%0t ns: %s", $time, msg);
	endtask

	task automatic send_poll(input logic a, input logic b, input logic btn, input time_t now,
	                         input bit fixed, input poll_result_t want);
		int gap;
		poll_result_t model_out;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		pin_a <= a;
		pin_b <= b;
		button_level <= btn;
		now_ms <= now;
		do @(posedge clk); while (in_stall);
		model_out = decode_poll(a, b, btn, now);
		pending_reports.push_back(fixed ? want : model_out);
		polls_sent++;
	endtask

	// drop valid, wait for every report, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// result side: hold stall for a drawn number of cycles, then take one beat
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = idle_on ? $urandom_range(0, 3) : 0;
			repeat (hold) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_report = {rotation_event, step_value, press_event, long_press_event,
			              button_debounced};
			if (pending_reports.size() == 0) begin
				log_fault($sformatf("report %0d arrived with nothing expected", reports_seen));
			end else begin
				want_report = pending_reports.pop_front();
				if (got_report !== want_report)
					log_fault($sformatf({"report %0d: expected rot %b step %0d press %b ",
						"long %b btn %b, got rot %b step %0d press %b long %b btn %b"},
						reports_seen, want_report.rot, $signed(want_report.step),
						want_report.press, want_report.lng, want_report.btn,
						got_report.rot, $signed(got_report.step), got_report.press,
						got_report.lng, got_report.btn));
			end
			reports_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timed out after %0d cycles, %0d reports outstanding", cycles,
			         pending_reports.size());
			$display("rotary_encoder_with_button: mismatch");
			$finish;
		end
	end

	initial begin
		logic en, present, lpe, ae;
		logic [15:0] deb, lp, thr;
		logic [7:0] rate;
		time_t gap_ms;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pin_a = 1'b0;
		pin_b = 1'b0;
		button_level = 1'b1;
		now_ms = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BLOCK_ENABLE;
		cfg_data = '0;
		cfg_en = RST_BLOCK_ENABLE;
		cfg_btn = RST_BUTTON_PRESENT;
		cfg_debounce = RST_DEBOUNCE_MS;
		cfg_long_ms = RST_LONG_PRESS_MS;
		cfg_long_en = RST_LONG_PRESS_ENABLE;
		cfg_accel_en = RST_ACCEL_ENABLE;
		cfg_rate = RST_ACCEL_RATE;
		cfg_thresh = RST_ACCEL_THRESHOLD_MS;
		armed = 1'b0;
		held_phase = '0;
		step_now = '0;
		enc_stamp = '0;
		spin_stamp = '0;
		raw_stamp = '0;
		press_stamp = '0;
		btn_settled = 1'b1;
		btn_last_raw = 1'b1;
		long_fired = 1'b0;
		faults = 0;
		reports_seen = 0;
		polls_sent = 0;
		settings_used = 1;
		cycles = 0;
		idle_on = 1'b1;

		// reset settings: debounce 5, long press 1000 (off), acceleration off
		directed_rows.push_back(poll_row(0, 0, 1, 32'd0, 1, '{1'b0, 9'sd0, 1'b0, 1'b0, 1'b1}));
		directed_rows.push_back(poll_row(0, 1, 1, 32'd10, 1, '{1'b1, 9'sd1, 1'b0, 1'b0, 1'b1}));
		directed_rows.push_back(poll_row(1, 1, 1, 32'd12));   // inside the debounce window
		directed_rows.push_back(poll_row(1, 0, 1, 32'd20));
		directed_rows.push_back(poll_row(1, 1, 1, 32'd30, 1, '{1'b1, -9'sd1, 1'b0, 1'b0, 1'b1}));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd40));   // skipped phase
		directed_rows.push_back(poll_row(0, 0, 0, 32'd50));
		directed_rows.push_back(poll_row(0, 0, 0, 32'd55, 1, '{1'b0, 9'sd0, 1'b1, 1'b0, 1'b0}));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd57));   // bouncing release
		directed_rows.push_back(poll_row(0, 0, 0, 32'd58));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd70));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd80));
		directed_rows.push_back(poll_row(0, 1, 1, 32'hFFFF_FFFF));
		directed_rows.push_back(poll_row(1, 1, 1, 32'd4));    // time wraps
		directed_rows.push_back(write_row(REG_LONG_PRESS_ENABLE, 16'd1));
		directed_rows.push_back(write_row(REG_LONG_PRESS_MS, 16'd20));
		directed_rows.push_back(write_row(REG_ACCEL_ENABLE, 16'd1));
		directed_rows.push_back(poll_row(1, 1, 0, 32'd100));
		directed_rows.push_back(poll_row(1, 0, 0, 32'd110));
		directed_rows.push_back(poll_row(0, 0, 0, 32'd130));  // fast step, long press
		directed_rows.push_back(poll_row(0, 0, 0, 32'd200));
		directed_rows.push_back(write_row(REG_ACCEL_RATE, 16'd0));
		directed_rows.push_back(poll_row(0, 1, 0, 32'd210));  // fast step times zero
		directed_rows.push_back(write_row(REG_ACCEL_RATE, 16'd255));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd220, 1,
		                                 '{1'b1, -9'sd255, 1'b0, 1'b0, 1'b0}));
		directed_rows.push_back(write_row(REG_BUTTON_PRESENT, 16'd0));
		directed_rows.push_back(poll_row(0, 0, 1, 32'd300));
		directed_rows.push_back(poll_row(0, 0, 0, 32'd400));
		directed_rows.push_back(write_row(REG_BLOCK_ENABLE, 16'hFFFE));   // masks to 0
		directed_rows.push_back(poll_row(1, 1, 1, 32'd500, 1, '{1'b0, 9'sd0, 1'b0, 1'b0, 1'b0}));
		directed_rows.push_back(write_row(REG_BLOCK_ENABLE, 16'd1));
		directed_rows.push_back(write_row(REG_BUTTON_PRESENT, 16'd1));
		directed_rows.push_back(poll_row(1, 1, 1, 32'd510));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].data);
			end else begin
				send_poll(directed_rows[i].a, directed_rows[i].b, directed_rows[i].btn,
				          directed_rows[i].now, directed_rows[i].fixed, directed_rows[i].want);
			end
		end

		ph_now = held_phase;
		clk_ms = $urandom;
		spin_cw = 1'b1;
		btn_goal = 1'b1;
		btn_raw = 1'b1;
		bounce_left = 0;
		hold_left = $urandom_range(0, 10);

		for (int p = 0; p < 9; p++) begin
			en = 1'b1;
			present = ($urandom_range(0, 4) != 0);
			deb = 16'($urandom_range(0, 12));
			lp = 16'($urandom_range(0, 300));
			lpe = 1'($urandom_range(0, 1));
			ae = ($urandom_range(0, 3) != 0);
			rate = 8'($urandom_range(0, 255));
			thr = 16'($urandom_range(0, 200));
			case (p)
				1: begin
					deb = '0; lp = '0; lpe = 1'b1; ae = 1'b1; rate = '0; thr = '0; present = 1'b1;
				end
				2: begin
					deb = '1; lp = '1; lpe = 1'b1; ae = 1'b1; rate = '1; thr = '1; present = 1'b1;
				end
				3: en = 1'b0;
				4: present = 1'b0;
				5: begin
					ae = 1'b1; rate = 8'd1; thr = '1;
				end
				default: ;
			endcase
			settle();
			// junk in the unused upper bits must be ignored
			write_reg(REG_DEBOUNCE_MS, deb);
			write_reg(REG_LONG_PRESS_MS, lp);
			write_reg(REG_ACCEL_THRESHOLD_MS, thr);
			write_reg(REG_ACCEL_RATE, {8'($urandom), rate});
			write_reg(REG_LONG_PRESS_ENABLE, {15'($urandom), lpe});
			write_reg(REG_ACCEL_ENABLE, {15'($urandom), ae});
			write_reg(REG_BUTTON_PRESENT, {15'($urandom), present});
			write_reg(REG_BLOCK_ENABLE, {15'($urandom), en});
			settings_used++;

			for (int n = 0; n < (p == 3 ? 20 : 88); n++) begin
				idle_on = !(n >= 40 && n < 60);
				if (p == 0 && n == 30)
					settle();   // hold off until every report is in

				case ($urandom_range(0, 19))
					0:       gap_ms = $urandom;
					1, 2:    gap_ms = '0;
					3, 4, 5: gap_ms = $urandom_range(0, cfg_debounce);
					6, 7, 8: gap_ms = $urandom_range(0, cfg_thresh + 16);
					default: gap_ms = $urandom_range(cfg_debounce, cfg_debounce + 40);
				endcase
				clk_ms = clk_ms + gap_ms;

				case ($urandom_range(0, 19))
					0:             spin_cw = ~spin_cw;
					1, 2:          ;   // hold the phase
					3, 4:          ph_now = 2'($urandom);
					default: begin
						// advance one gray step
						ph_pos = {ph_now[1], ph_now[1] ^ ph_now[0]};
						ph_pos = spin_cw ? ph_pos + 2'd1 : ph_pos - 2'd1;
						ph_now = {ph_pos[1], ph_pos[1] ^ ph_pos[0]};
					end
				endcase

				if (hold_left == 0) begin
					btn_goal = ~btn_goal;
					bounce_left = $urandom_range(0, 3);
					hold_left = btn_goal ? $urandom_range(5, 60) : $urandom_range(1, 30);
				end else begin
					hold_left--;
				end
				if (bounce_left != 0) begin
					bounce_left--;
					btn_raw = 1'($urandom);
				end else begin
					btn_raw = btn_goal;
				end

				send_poll(ph_now[1], ph_now[0], btn_raw, clk_ms, 1'b0, '0);
			end
		end
		settle();

		$display("%0d polls sent, %0d reports checked, %0d register settings, %0d faults",
		         polls_sent, reports_seen, settings_used, faults);
		$display("covered debounce, acceleration, wrap of time, button press and hold, disable");
		if (faults == 0)
			$display("rotary_encoder_with_button: match");
		else
			$display("rotary_encoder_with_button: mismatch");
		$finish;
	end

endmodule
